// File: src/rrg_pkg.sv
// ----------------------------------------------------------------------------
// rrg_pkg: shared types and constants for the ranged random generator
// Item structs, generator constants and the controller/datapath interface.
// ----------------------------------------------------------------------------
package rrg_pkg;

  localparam int MIX_SHIFT = 33;
  localparam int DIV_STEPS = 32;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [63:0] MIX_MULT = 64'd1111111111111111111;
  localparam logic [63:0] LCG_MULT = 64'h3243f6a8885a308d;

  localparam logic CMD_MIX  = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic signed [63:0] mix_value;
    logic signed [31:0] min_value;
    logic signed [31:0] max_value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] random_value;
    logic               range_error;
  } out_t;

  // Which 32x32 partial product the shared multiplier forms
  typedef enum logic [1:0] {
    MUL_LL,
    MUL_LH,
    MUL_HL
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     mix_add;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_init;
    logic     acc_add;
    logic     fin;
    logic     div_step;
    logic     res_load;
  } dp_cmd_t;

  typedef struct packed {
    logic draw;
    logic range_bad;
  } dp_status_t;

endpackage

// File: src/rrg_datapath.sv
// ----------------------------------------------------------------------------
// rrg_datapath: generator state, shared multiplier and restoring divider
// Executes one command per cycle from the controller; holds the result data.
// ----------------------------------------------------------------------------
module rrg_datapath (
  input  logic                clk,
  input  logic                rst,
  input  rrg_pkg::in_t        in_data,
  input  rrg_pkg::dp_cmd_t    cmd,
  output rrg_pkg::dp_status_t status,
  output rrg_pkg::out_t       out_data
);

  logic [63:0] rng_state;
  logic [63:0] acc;
  logic [63:0] prod;
  logic [63:0] mix_value;
  logic [31:0] lo;
  logic [32:0] range;
  logic        draw;
  logic        range_bad;
  logic [31:0] dvd;
  logic [31:0] rem;

  logic [32:0] diff;
  logic [63:0] mult;
  logic [31:0] a_half;
  logic [31:0] c_half;
  logic [63:0] acc_inc;
  logic [32:0] rem_shift;
  logic [32:0] trial;

  assign diff = {in_data.max_value[31], in_data.max_value}
              - {in_data.min_value[31], in_data.min_value};

  assign mult    = draw ? rrg_pkg::LCG_MULT : rrg_pkg::MIX_MULT;
  assign acc_inc = acc + 64'd1;

  always_comb begin
    case (cmd.mul_sel)
      rrg_pkg::MUL_LL: begin
        a_half = rng_state[31:0];
        c_half = mult[31:0];
      end
      rrg_pkg::MUL_LH: begin
        a_half = rng_state[31:0];
        c_half = mult[63:32];
      end
      rrg_pkg::MUL_HL: begin
        a_half = rng_state[63:32];
        c_half = mult[31:0];
      end
      default: begin
        a_half = rng_state[31:0];
        c_half = mult[31:0];
      end
    endcase
  end

  // Restoring division step: remainder stays below range, so 32 bits hold it
  assign rem_shift = {rem, dvd[31]};
  assign trial     = rem_shift - range;

  always_ff @(posedge clk) begin
    if (rst) begin
      rng_state <= '0;
    end else if (cmd.mix_add) begin
      rng_state <= rng_state + mix_value;
    end else if (cmd.fin) begin
      if (draw) begin
        rng_state <= acc_inc;
      end else begin
        rng_state <= acc ^ (acc >> rrg_pkg::MIX_SHIFT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      draw      <= (in_data.cmd == rrg_pkg::CMD_DRAW);
      mix_value <= in_data.mix_value;
      lo        <= in_data.min_value;
      range_bad <= diff[32];
      range     <= diff + 33'd1;
    end
    if (cmd.mul_en) begin
      prod <= a_half * c_half;
    end
    if (cmd.acc_init) begin
      acc <= prod;
    end else if (cmd.acc_add) begin
      acc[63:32] <= acc[63:32] + prod[31:0];
    end
    if (cmd.fin && draw) begin
      dvd <= acc_inc[63:32];
      rem <= '0;
    end
    if (cmd.div_step) begin
      dvd <= {dvd[30:0], 1'b0};
      if (rem_shift >= range) begin
        rem <= trial[31:0];
      end else begin
        rem <= rem_shift[31:0];
      end
    end
    if (cmd.res_load) begin
      if (range_bad) begin
        out_data.random_value <= lo;
        out_data.range_error  <= 1'b1;
      end else begin
        out_data.random_value <= rem + lo;
        out_data.range_error  <= 1'b0;
      end
    end
  end

  assign status.draw      = draw;
  assign status.range_bad = range_bad;

endmodule

// File: src/rrg_controller.sv
// ----------------------------------------------------------------------------
// rrg_controller: command sequencer for the ranged random generator
// Steps the datapath through mix, multiply, divide and result phases.
// ----------------------------------------------------------------------------
module rrg_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  rrg_pkg::dp_status_t status,
  output rrg_pkg::dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_FIN,
    S_DIV,
    S_RES
  } state_t;

  state_t                  state;
  state_t                  state_next;
  logic [rrg_pkg::CNT_W-1:0] cnt;
  logic                    in_xfer;
  logic                    out_free;

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd         = '0;
    cmd.mul_sel = rrg_pkg::MUL_LL;
    state_next  = state;
    unique case (state)
      S_IDLE: begin
        cmd.load = in_xfer;
        if (in_xfer) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (!status.draw) begin
          cmd.mix_add = 1'b1;
          state_next  = S_MUL0;
        end else if (status.range_bad) begin
          state_next = S_RES;
        end else begin
          state_next = S_MUL0;
        end
      end
      S_MUL0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = rrg_pkg::MUL_LL;
        state_next  = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = rrg_pkg::MUL_LH;
        cmd.acc_init = 1'b1;
        state_next   = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = rrg_pkg::MUL_HL;
        cmd.acc_add = 1'b1;
        state_next  = S_MUL3;
      end
      S_MUL3: begin
        cmd.acc_add = 1'b1;
        state_next  = S_FIN;
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = status.draw ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == rrg_pkg::CNT_W'(rrg_pkg::DIV_STEPS - 1)) state_next = S_RES;
      end
      S_RES: begin
        // hold until the output register frees up
        cmd.res_load = out_free;
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DIV) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> state == S_DECODE)
    else $error("accepted item did not enter decode");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken result");

  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && cnt == rrg_pkg::CNT_W'(rrg_pkg::DIV_STEPS - 1)) |=> state == S_RES)
    else $error("divider did not finish after its last step");

  a_mix_no_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && !status.draw) |=> state == S_IDLE)
    else $error("mix command did not return to idle");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |=> out_valid)
    else $error("result loaded without raising valid");

endmodule

// File: src/ranged_random_generator.sv
// ----------------------------------------------------------------------------
// ranged_random_generator: 64-bit LCG with mix and ranged draw commands
// Input channel carries cmd, mix_value, min_value and max_value; a draw
// returns one result (random_value, range_error), a mix returns nothing.
// Usage:
//   in_valid/in_ready/in_data take one command per transfer; in_ready is high
//   only while the block is idle, so one command is in flight at a time.
//   out_valid/out_ready/out_data deliver draw results from an output register.
// Command steps:
//   mix  : add, 3 partial products on one shared 32x32 multiplier,
//          accumulate, xor-shift; in_ready returns after the xor-shift.
//   draw : the same multiply and accumulate steps, then the 32-step
//          restoring divider that forms the modulo, then the result step.
//   draw with max below min: returns min with range_error set.
// Reset: synchronous rst clears the controller, the output valid and the
//   generator state, which starts at zero.
// Stall: a result waiting on out_ready holds in the output register; the next
//   command is accepted meanwhile, and a new draw waits at its result step.
// ----------------------------------------------------------------------------
module ranged_random_generator (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rrg_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rrg_pkg::out_t out_data
);

  rrg_pkg::dp_cmd_t    dp_cmd;
  rrg_pkg::dp_status_t dp_status;
  rrg_pkg::out_t       res;
  logic                seq_in_ready;

  rrg_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (seq_in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (dp_status),
    .cmd       (dp_cmd)
  );

  rrg_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (dp_cmd),
    .status   (dp_status),
    .out_data (res)
  );

  assign in_ready = seq_in_ready;
  assign out_data = res;

endmodule
